// ===== rtl/wait_for_graph_cycle_guard_macros.svh =====
// assertion macros for the wait-for graph cycle guard
`ifndef WAIT_FOR_GRAPH_CYCLE_GUARD_MACROS_SVH
`define WAIT_FOR_GRAPH_CYCLE_GUARD_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WFG_CHECK_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfg check failed");
`define WFG_CHECK_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfg check failed");
`else
`define WFG_CHECK_IMPL(name, clk, rst_n, ante, cons)
`define WFG_CHECK_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/wfg_pkg.sv =====
// shared types and constants of the wait-for graph cycle guard
`timescale 1ns / 1ps
package wfg_pkg;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam int IN_IDX_W    = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_PASS,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [IN_IDX_W-1:0]   waiter;
    logic [IN_IDX_W-1:0]   holder;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== rtl/wfg_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module wfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wfg_front.sv =====
// front end: accepts requests, classifies them and queues them for the engine
`timescale 1ns / 1ps
`include "wait_for_graph_cycle_guard_macros.svh"
module wfg_front #(
  parameter int MAX_THREADS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic [wfg_pkg::IN_IDX_W-1:0]       in_waiter,
  input  logic [wfg_pkg::IN_IDX_W-1:0]       in_holder,
  input  logic                               pop,
  output wfg_pkg::queue_head_t               head
);

  localparam int PTR_W = $clog2(wfg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(wfg_pkg::QUEUE_DEPTH + 1);

  wfg_pkg::cmd_t     entries_r [wfg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  logic              in_range;
  wfg_pkg::cmd_t     cmd;

  // range check and classification
  assign in_range = (int'(in_waiter) < MAX_THREADS) && (int'(in_holder) < MAX_THREADS);

  always_comb begin
    cmd.waiter = in_waiter;
    cmd.holder = in_holder;
    priority if (in_action == wfg_pkg::ACT_REMOVE) begin
      cmd.kind = in_range ? wfg_pkg::CMD_REMOVE : wfg_pkg::CMD_PASS;
    end else if (!in_range || (in_waiter == in_holder)) begin
      cmd.kind = wfg_pkg::CMD_REJECT;
    end else begin
      cmd.kind = wfg_pkg::CMD_ADD;
    end
  end

  assign busy = (count_r == CNT_W'(wfg_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  assign wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
  assign rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign count_nxt  = CNT_W'(count_r + CNT_W'(push) - CNT_W'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = entries_r[rd_ptr_r];

  `WFG_CHECK_NEXT(a_push_fills, clk, rst_n, start && !busy, count_r != '0)
  `WFG_CHECK_IMPL(a_pop_from_filled, clk, rst_n, pop, count_r != '0)
  `WFG_CHECK_IMPL(a_count_bounded, clk, rst_n, 1'b1, count_r <= CNT_W'(wfg_pkg::QUEUE_DEPTH))

endmodule

// ===== rtl/wfg_back.sv =====
// back end: reachability search over the wait matrix and edge update
`timescale 1ns / 1ps
`include "wait_for_graph_cycle_guard_macros.svh"
module wfg_back #(
  parameter int MAX_THREADS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wfg_pkg::queue_head_t  head,
  output logic                  pop,
  output logic                  out_valid,
  output logic                  out_accepted
);

  localparam int IDX_W = $clog2(MAX_THREADS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [MAX_THREADS-1:0] reached_r, reached_nxt;
  logic [MAX_THREADS-1:0] expanded_r, expanded_nxt;
  logic [MAX_THREADS-1:0] row_valid_r, row_valid_nxt;
  logic                   fresh_r, fresh_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic [IDX_W-1:0]       waiter_r, waiter_nxt;
  logic [IDX_W-1:0]       holder_r, holder_nxt;
  logic                   set_r, set_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_accepted_r, out_accepted_nxt;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [MAX_THREADS-1:0] wdata;
  logic [IDX_W-1:0]       raddr;
  logic [MAX_THREADS-1:0] rdata;

  logic [MAX_THREADS-1:0] row;
  logic [MAX_THREADS-1:0] merged;
  logic [MAX_THREADS-1:0] pending;
  logic [IDX_W-1:0]       next_pick;
  logic [IDX_W-1:0]       head_waiter;
  logic [IDX_W-1:0]       head_holder;
  logic [MAX_THREADS-1:0] holder_bit;

  function automatic logic [IDX_W-1:0] first_set(input logic [MAX_THREADS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  wfg_ram #(
    .WIDTH (MAX_THREADS),
    .DEPTH (MAX_THREADS)
  ) u_matrix (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rows never written since reset read as empty
  assign row         = row_valid_r[pick_r] ? rdata : '0;
  assign merged      = reached_r | (fresh_r ? row : '0);
  assign pending     = merged & ~expanded_r;
  assign next_pick   = first_set(pending);
  assign head_waiter = IDX_W'(head.cmd.waiter);
  assign head_holder = IDX_W'(head.cmd.holder);
  assign holder_bit  = MAX_THREADS'(1) << holder_r;

  always_comb begin
    state_nxt        = state_r;
    reached_nxt      = reached_r;
    expanded_nxt     = expanded_r;
    row_valid_nxt    = row_valid_r;
    fresh_nxt        = 1'b0;
    pick_nxt         = pick_r;
    waiter_nxt       = waiter_r;
    holder_nxt       = holder_r;
    set_nxt          = set_r;
    out_valid_nxt    = 1'b0;
    out_accepted_nxt = out_accepted_r;
    pop              = 1'b0;
    raddr            = pick_r;
    we               = 1'b0;
    waddr            = pick_r;
    wdata            = set_r ? (row | holder_bit) : (row & ~holder_bit);
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          waiter_nxt = head_waiter;
          holder_nxt = head_holder;
          unique case (head.cmd.kind)
            wfg_pkg::CMD_ADD: begin
              reached_nxt  = MAX_THREADS'(1) << head_holder;
              expanded_nxt = '0;
              state_nxt    = S_SCAN;
            end
            wfg_pkg::CMD_REMOVE: begin
              set_nxt   = 1'b0;
              pick_nxt  = head_waiter;
              raddr     = head_waiter;
              state_nxt = S_RMW;
            end
            wfg_pkg::CMD_PASS: begin
              out_valid_nxt    = 1'b1;
              out_accepted_nxt = 1'b1;
            end
            wfg_pkg::CMD_REJECT: begin
              out_valid_nxt    = 1'b1;
              out_accepted_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        reached_nxt = merged;
        priority if (merged[waiter_r]) begin
          // waiter reachable from holder: edge would close a cycle
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = 1'b0;
          state_nxt        = S_IDLE;
        end else if (pending == '0) begin
          set_nxt   = 1'b1;
          pick_nxt  = waiter_r;
          raddr     = waiter_r;
          state_nxt = S_RMW;
        end else begin
          pick_nxt     = next_pick;
          raddr        = next_pick;
          expanded_nxt = expanded_r | (MAX_THREADS'(1) << next_pick);
          fresh_nxt    = 1'b1;
        end
      end
      S_RMW: begin
        we                    = 1'b1;
        row_valid_nxt[pick_r] = 1'b1;
        out_valid_nxt         = 1'b1;
        out_accepted_nxt      = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      reached_r      <= '0;
      expanded_r     <= '0;
      row_valid_r    <= '0;
      fresh_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      reached_r      <= reached_nxt;
      expanded_r     <= expanded_nxt;
      row_valid_r    <= row_valid_nxt;
      fresh_r        <= fresh_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r         <= pick_nxt;
    waiter_r       <= waiter_nxt;
    holder_r       <= holder_nxt;
    set_r          <= set_nxt;
    out_accepted_r <= out_accepted_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;

  `WFG_CHECK_IMPL(a_expanded_in_reached, clk, rst_n, 1'b1, (expanded_r & ~reached_r) == '0)
  `WFG_CHECK_NEXT(a_rmw_reports, clk, rst_n, state_r == S_RMW, out_valid_r && out_accepted_r)
  `WFG_CHECK_NEXT(a_add_starts_scan, clk, rst_n, pop && (head.cmd.kind == wfg_pkg::CMD_ADD), (state_r == S_SCAN) && !out_valid_r)

endmodule

// ===== rtl/wait_for_graph_cycle_guard.sv =====
// top level of the wait-for graph cycle guard
// A request is taken at a rising edge with start high and busy low. in_action
// selects add (cycle checked) or remove of the edge in_waiter -> in_holder.
// Requests enter a two-entry queue; busy is high while that queue is full.
// Each request yields one beat on out_valid/out_accepted, valid for one cycle,
// in request order. out_accepted is 0 for an add that would close a cycle,
// is a self edge or has an index at or above MAX_THREADS; 1 otherwise.
// Work between accept and result beat, with the engine free:
//   out-of-range requests and self-edge adds: answered from the idle state
//   remove: read-modify-write of one matrix row
//   add: the search expands one reached thread per cycle through the single
//   read port of the matrix ram, and stops early once the waiter is found
//   reachable
// With the queue kept full the engine takes one out-of-range request or self
// edge add per cycle; a remove or an add holds the engine until its result
// beat is shown.
// Reset clears the graph at once through per-row valid bits, empties the
// queue and idles the engine. The receiver cannot stall: every result beat
// must be taken in the cycle it is shown.
`timescale 1ns / 1ps
module wait_for_graph_cycle_guard #(
  parameter int MAX_THREADS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [wfg_pkg::IN_IDX_W-1:0] in_waiter,
  input  logic [wfg_pkg::IN_IDX_W-1:0] in_holder,
  output logic                         out_valid,
  output logic                         out_accepted
);

  wfg_pkg::queue_head_t head;
  logic                 pop;

  wfg_front #(
    .MAX_THREADS (MAX_THREADS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_action (in_action),
    .in_waiter (in_waiter),
    .in_holder (in_holder),
    .pop       (pop),
    .head      (head)
  );

  wfg_back #(
    .MAX_THREADS (MAX_THREADS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_accepted (out_accepted)
  );

endmodule
